// File: design/swf_pkg.sv
// Shared types and constants for the sync word framer.
package swf_pkg;

  localparam int AMP_W   = 15;
  localparam int SYNC_W  = 32;
  localparam int LEN_W   = 8;
  localparam int BYTE_W  = 8;
  localparam int CRC_W   = 8;
  localparam int LEVEL_W = 16;

  // CRC-8 generator polynomial x^8+x^2+x+1.
  localparam logic [CRC_W-1:0] CRC_POLY = 8'h07;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_AMPLITUDE     = 2'd0;
  localparam logic [1:0] REG_SYNC_WORD     = 2'd1;
  localparam logic [1:0] REG_PAYLOAD_BYTES = 2'd2;

  // Job handed from the front end to the serializer.
  typedef struct packed {
    logic [BYTE_W-1:0] byte_val;
    logic              send_sync;
    logic [SYNC_W-1:0] sync;
    logic              send_crc;
    logic [CRC_W-1:0]  crc;
  } swf_entry_t;

endpackage

// File: design/swf_front.sv
// Front end: tracks frame position, runs the CRC and classifies each byte.
module swf_front import swf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [SYNC_W-1:0] sync_pattern,
  input  logic [LEN_W-1:0]  payload_bytes,
  input  logic [BYTE_W-1:0] byte_value,
  input  logic              take,
  output swf_entry_t        entry
);

  localparam logic [LEN_W-1:0] MIN_LEN  = 8'd2;

  logic [LEN_W-1:0] pos;
  logic [CRC_W-1:0] crc;

  logic [LEN_W-1:0] len;
  logic [LEN_W-1:0] pos_inc;
  logic             first;
  logic             is_last;
  logic [CRC_W-1:0] crc_new;

  // Bitwise CRC-8, eight shift steps on one byte.
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] c,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] r;
    r = c ^ b;
    for (int i = 0; i < 8; i++) begin
      if (r[CRC_W-1]) r = (r << 1) ^ CRC_POLY;
      else r = r << 1;
    end
    return r;
  endfunction

  always_comb begin
    len     = (payload_bytes < MIN_LEN) ? MIN_LEN : payload_bytes;
    first   = (pos == '0);
    pos_inc = pos + 1'b1;
    is_last = (pos_inc >= len);
    crc_new = crc_byte(first ? '0 : crc, byte_value);

    entry.byte_val  = byte_value;
    entry.send_sync = first;
    entry.sync      = sync_pattern;
    entry.send_crc  = is_last;
    entry.crc       = crc_new;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      crc <= '0;
    end else if (take) begin
      pos <= is_last ? '0 : pos_inc;
      crc <= is_last ? '0 : crc_new;
    end
  end

endmodule

// File: design/swf_queue.sv
// Two-entry queue between the front end and the serializer.
module swf_queue import swf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  swf_entry_t push_data,
  input  logic       pop,
  output swf_entry_t head,
  output logic       full,
  output logic       nonempty
);

  swf_entry_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full     = (count == 2'd2);
  assign nonempty = (count != 2'd0);
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;
  assign head     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: design/swf_back.sv
// Serializer: shifts out sync, data and CRC bits as BPSK symbols.
module swf_back import swf_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [AMP_W-1:0]          amplitude,
  input  swf_entry_t                head,
  input  logic                      head_valid,
  output logic                      pop,
  output logic signed [LEVEL_W-1:0] level,
  output logic                      symbol_bit,
  output logic                      frame_end,
  output logic                      last,
  output logic                      sym_valid,
  input  logic                      sym_ready
);

  localparam int SH_W = SYNC_W + BYTE_W + CRC_W;

  logic [SH_W-1:0] sh;
  logic [5:0]      rem;
  logic            has_crc;

  logic            out_free;
  logic            emit;
  logic            load;
  logic [SH_W-1:0] sh_load;
  logic [5:0]      rem_load;
  logic [LEVEL_W-1:0] mag;

  assign out_free = !sym_valid || sym_ready;
  assign emit     = (rem != 6'd0) && out_free;
  assign load     = head_valid && ((rem == 6'd0) || (emit && rem == 6'd1));
  assign pop      = load;
  assign mag      = {1'b0, amplitude};

  always_comb begin
    if (head.send_sync) sh_load = {head.sync, head.byte_val, head.crc};
    else sh_load = {head.byte_val, head.crc, {SYNC_W{1'b0}}};
    rem_load = 6'd8 + (head.send_sync ? 6'd32 : 6'd0) + (head.send_crc ? 6'd8 : 6'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rem       <= '0;
      sym_valid <= 1'b0;
    end else begin
      if (load) begin
        rem <= rem_load;
      end else if (emit) begin
        rem <= rem - 6'd1;
      end
      if (emit) sym_valid <= 1'b1;
      else if (sym_ready) sym_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sh      <= sh_load;
      has_crc <= head.send_crc;
    end else if (emit) begin
      sh <= sh << 1;
    end
    if (emit) begin
      symbol_bit <= sh[SH_W-1];
      level      <= sh[SH_W-1] ? $signed(mag) : $signed(LEVEL_W'(0) - mag);
      last       <= (rem == 6'd1);
      frame_end  <= (rem == 6'd1) && has_crc;
    end
  end

endmodule

// File: design/sync_word_framer_crc8_bpsk.sv
// Top level of the sync word framer with CRC-8 and BPSK symbol output.
//
// This block turns payload bytes into a serial BPSK symbol stream, one
// symbol per beat on the sym channel. The first byte of a frame is preceded
// by the 32-bit sync word, every byte goes out most significant bit first,
// and after the last payload byte the 8-bit CRC (polynomial 0x07, initial
// value zero) follows, with frame_end marking its final bit. Each symbol is
// +amplitude for a one and -amplitude for a zero, and last marks the final
// symbol caused by an input byte. A frame length below two is treated as
// two. The serializer emits one symbol per clock while it has bits to send
// and the receiver keeps up; a two-entry queue in front of the serializer
// lets the byte input run ahead while symbols drain. Configuration
// registers are written through cfg_we, cfg_index and cfg_data and should
// only be changed while the block is idle.
module sync_word_framer_crc8_bpsk import swf_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  // Configuration write port.
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [SYNC_W-1:0]         cfg_data,
  // Byte input channel.
  input  logic                      byte_valid,
  output logic                      byte_ready,
  input  logic [BYTE_W-1:0]         byte_value,
  // Symbol output channel.
  output logic                      sym_valid,
  input  logic                      sym_ready,
  output logic signed [LEVEL_W-1:0] level,
  output logic                      symbol_bit,
  output logic                      frame_end,
  output logic                      last
);

  logic [AMP_W-1:0]  amplitude;
  logic [SYNC_W-1:0] sync_pattern;
  logic [LEN_W-1:0]  payload_bytes;

  swf_entry_t front_entry;
  swf_entry_t head;
  logic       q_full;
  logic       q_nonempty;
  logic       q_pop;
  logic       take;

  // Configuration registers; writes to the unused index are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      amplitude     <= AMP_W'(15000);
      sync_pattern  <= 32'h1ACF_FC1D;
      payload_bytes <= LEN_W'(63);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_AMPLITUDE:     amplitude     <= cfg_data[AMP_W-1:0];
        REG_SYNC_WORD:     sync_pattern  <= cfg_data;
        REG_PAYLOAD_BYTES: payload_bytes <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // A byte is taken whenever the queue has room for its entry.
  assign byte_ready = !q_full;
  assign take       = byte_valid && byte_ready;

  swf_front u_front (
    .clk           (clk),
    .rst           (rst),
    .sync_pattern  (sync_pattern),
    .payload_bytes (payload_bytes),
    .byte_value    (byte_value),
    .take          (take),
    .entry         (front_entry)
  );

  swf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (take),
    .push_data (front_entry),
    .pop       (q_pop),
    .head      (head),
    .full      (q_full),
    .nonempty  (q_nonempty)
  );

  // The serializer reloads from the queue in the same cycle that it sends
  // the final symbol of the previous byte, so the stream has no gaps while the queue holds the next byte.
  swf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .amplitude  (amplitude),
    .head       (head),
    .head_valid (q_nonempty),
    .pop        (q_pop),
    .level      (level),
    .symbol_bit (symbol_bit),
    .frame_end  (frame_end),
    .last       (last),
    .sym_valid  (sym_valid),
    .sym_ready  (sym_ready)
  );

endmodule

// File: bench/tb_sync_word_framer_crc8_bpsk.sv
// Self-checking testbench for the sync word framer with CRC-8 and BPSK levels.
`timescale 1ns / 1ps

module tb_sync_word_framer_crc8_bpsk import swf_pkg::*; ();

  // Index three selects no register, and writes to it must leave the block
  // unchanged.
  localparam logic [1:0] REG_UNUSED        = 2'd3;

  localparam logic [AMP_W-1:0]  AMP_RESET     = 15'd15000;
  localparam logic [SYNC_W-1:0] SYNC_RESET    = 32'h1ACFFC1D;
  localparam logic [LEN_W-1:0]  LEN_RESET     = 8'd63;
  localparam logic [AMP_W-1:0]  AMP_MAX       = 15'h7FFF;
  localparam int MIN_FRAME_LEN  = 2;
  localparam int RANDOM_ITEMS   = 460;
  localparam int MAX_REPORTS    = 10;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 400;
  localparam int TAIL_CYCLES    = 40;

  // One symbol as it is expected on the output channel.
  typedef struct packed {
    logic signed [LEVEL_W-1:0] level;
    logic                      symbol_bit;
    logic                      frame_end;
    logic                      last;
  } symbol_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [SYNC_W-1:0] cfg_data;
  logic byte_valid;
  logic byte_ready;
  logic [BYTE_W-1:0] byte_value;
  logic sym_valid;
  logic sym_ready = 1'b0;
  logic signed [LEVEL_W-1:0] level;
  logic symbol_bit;
  logic frame_end;
  logic last;

  // Shadow copy of the configuration registers. It is only changed by
  // write_reg, which runs while the block is idle.
  logic [AMP_W-1:0]  model_amp  = AMP_RESET;
  logic [SYNC_W-1:0] model_sync = SYNC_RESET;
  logic [LEN_W-1:0]  model_len  = LEN_RESET;

  // Frame state of the predictor: running CRC and bytes taken so far.
  logic [CRC_W-1:0] frame_crc;
  logic [LEN_W-1:0] frame_pos;

  symbol_t expected_syms[$];
  int mismatches   = 0;
  int quiet_cycles = 0;

  // Idle controls. The steady flags switch off random gaps on one side;
  // rx_hold_req asks the receiver process for one long hold-off.
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  int rx_hold_req = 0;
  int rx_stall = 0;

  sync_word_framer_crc8_bpsk DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_value (byte_value),
    .sym_valid  (sym_valid),
    .sym_ready  (sym_ready),
    .level      (level),
    .symbol_bit (symbol_bit),
    .frame_end  (frame_end),
    .last       (last)
  );

  always #5 clk = ~clk;

  // Length of an idle stretch: zero with the given chance in percent, else
  // mostly a short one and now and then a long one.
  function automatic int idle_length(input int zero_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < zero_pct) return 0;
    if (r < 100 - (100 - zero_pct) / 5) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Appends one expected symbol. The level is the current amplitude with
  // the sign taken from the bit.
  task automatic push_symbol(input logic sbit, input logic fend, input logic lst);
    symbol_t s;
    s.level      = sbit ? $signed({1'b0, model_amp}) : -$signed({1'b0, model_amp});
    s.symbol_bit = sbit;
    s.frame_end  = fend;
    s.last       = lst;
    expected_syms.push_back(s);
  endtask

  task automatic check_field(input string name, input logic [LEVEL_W-1:0] want,
                             input logic [LEVEL_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("mismatch in %s at %0t: expected %h, got %h", name, $realtime, want, got);
    end
  endtask

  // Predictor and checker share one process, so a byte's symbols are queued
  // before any symbol of the same edge is compared, whatever order the
  // simulator picks for processes woken by the same clock edge.
  always @(posedge clk) begin : scoreboard
    logic [CRC_W-1:0] crc;
    logic ends;
    int eff_len;
    symbol_t want;
    if (rst) begin
      frame_crc = '0;
      frame_pos = '0;
    end else begin
      if (byte_valid && byte_ready) begin
        // A frame length of zero or one is treated as two.
        eff_len = (model_len < MIN_FRAME_LEN) ? MIN_FRAME_LEN : model_len;
        // The first byte of a frame is preceded by the sync word, MSB first.
        if (frame_pos == 0) begin
          frame_crc = '0;
          for (int i = SYNC_W - 1; i >= 0; i--) push_symbol(model_sync[i], 1'b0, 1'b0);
        end
        // CRC-8 over the byte, MSB first, no reflection and no final xor.
        crc = frame_crc ^ byte_value;
        for (int i = 0; i < 8; i++) crc = crc[7] ? ((crc << 1) ^ CRC_POLY) : (crc << 1);
        frame_crc = crc;
        frame_pos = frame_pos + 1'b1;
        // The frame closes once the byte count reaches the current length,
        // even when the length was lowered while the frame was open.
        ends = (frame_pos >= eff_len);
        for (int i = BYTE_W - 1; i >= 0; i--)
          push_symbol(byte_value[i], 1'b0, !ends && (i == 0));
        if (ends) begin
          for (int i = CRC_W - 1; i >= 0; i--) push_symbol(frame_crc[i], i == 0, i == 0);
          frame_crc = '0;
          frame_pos = '0;
        end
      end
      if (sym_valid && sym_ready) begin
        if (expected_syms.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("symbol with no expectation at %0t: level %0d", $realtime, level);
        end else begin
          want = expected_syms.pop_front();
          check_field("level", want.level, level);
          check_field("symbol_bit", want.symbol_bit, symbol_bit);
          check_field("frame_end", want.frame_end, frame_end);
          check_field("last", want.last, last);
        end
      end
    end
  end

  // Receiver: random stalls, stretches without any, and on request one long
  // hold-off that is counted here so the block fills up and stalls its input.
  always @(posedge clk) begin : receiver
    int n;
    if (rst) begin
      sym_ready <= 1'b0;
      rx_stall = 0;
    end else if (rx_hold_req > 0) begin
      sym_ready <= 1'b0;
      rx_stall = rx_hold_req - 1;
      rx_hold_req = 0;
    end else if (rx_stall > 0) begin
      sym_ready <= 1'b0;
      rx_stall--;
    end else begin
      n = rx_steady ? 0 : idle_length(85);
      if (n == 0) begin
        sym_ready <= 1'b1;
      end else begin
        sym_ready <= 1'b0;
        rx_stall = n - 1;
      end
    end
  end

  // Watchdog: a run that moves no beat on either channel for too long has
  // hung.
  always @(posedge clk) begin
    if (rst || (byte_valid && byte_ready) || (sym_valid && sym_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Offers one byte after a random gap and returns at the edge where it is
  // taken. Valid stays high on return, so back-to-back bytes need no gap.
  task automatic send_byte(input logic [BYTE_W-1:0] value);
    int gap;
    gap = tx_steady ? 0 : idle_length(60);
    if (gap > 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_value <= value;
    @(posedge clk);
    while (!byte_ready) @(posedge clk);
  endtask

  // Stops offering bytes and waits until every expected symbol has come.
  // The first edge lets the scoreboard queue the last byte's symbols.
  task automatic wait_symbols_drained();
    byte_valid <= 1'b0;
    @(posedge clk);
    while (expected_syms.size() != 0) @(posedge clk);
  endtask

  // Writes one register and mirrors it in the shadow copy. Only called
  // while the block is idle.
  task automatic write_reg(input logic [1:0] idx, input logic [SYNC_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_AMPLITUDE:     model_amp  = data[AMP_W-1:0];
      REG_SYNC_WORD:     model_sync = data;
      REG_PAYLOAD_BYTES: model_len  = data[LEN_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // A few bytes with the reset configuration: default sync word, amplitude
  // and a 63-byte frame that is left open.
  task automatic test_reset_values();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hA5);
  endtask

  // Register changes inside an open frame. Lowering the length below the
  // byte count closes the frame on the next byte; a new sync word leaves the
  // current frame alone; a new amplitude applies to the following symbols.
  task automatic test_mid_frame_changes();
    wait_symbols_drained();
    write_reg(REG_PAYLOAD_BYTES, 32'd2);
    send_byte(8'h5A);
    send_byte(8'h3C);
    wait_symbols_drained();
    write_reg(REG_SYNC_WORD, $urandom());
    send_byte(8'hC3);
    send_byte(8'h81);
    wait_symbols_drained();
    write_reg(REG_AMPLITUDE, 32'd1);
    send_byte(8'h7E);
  endtask

  // Frame lengths of zero and one both give two-byte frames.
  task automatic test_short_lengths();
    wait_symbols_drained();
    write_reg(REG_PAYLOAD_BYTES, 32'd0);
    send_byte(8'h01);
    send_byte(8'h80);
    wait_symbols_drained();
    write_reg(REG_PAYLOAD_BYTES, 32'd1);
    send_byte(8'hE7);
    send_byte(8'h18);
  endtask

  // Largest and zero amplitude with all-ones and all-zeros sync words.
  task automatic test_field_extremes();
    wait_symbols_drained();
    write_reg(REG_PAYLOAD_BYTES, 32'd2);
    write_reg(REG_AMPLITUDE, {17'h1FFFF, AMP_MAX});
    write_reg(REG_SYNC_WORD, 32'hFFFF_FFFF);
    send_byte(8'hFF);
    send_byte(8'h00);
    wait_symbols_drained();
    write_reg(REG_AMPLITUDE, 32'd0);
    write_reg(REG_SYNC_WORD, 32'd0);
    send_byte(8'h00);
    send_byte(8'hFF);
  endtask

  // A write to the index with no register behind it must change nothing.
  task automatic test_unused_index();
    wait_symbols_drained();
    write_reg(REG_AMPLITUDE, 32'd12345);
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    write_reg(REG_UNUSED, 32'd0);
    send_byte(8'h96);
    send_byte(8'h69);
  endtask

  // The receiver holds off for a long stretch while the sender keeps
  // offering bytes back to back, so the input queue fills and stalls.
  task automatic test_backpressure();
    wait_symbols_drained();
    write_reg(REG_PAYLOAD_BYTES, 32'd3);
    rx_hold_req = HOLD_CYCLES;
    tx_steady = 1'b1;
    repeat (12) send_byte($urandom_range(0, 255));
    tx_steady = 1'b0;
  endtask

  // Random phases: each one draws a new configuration (extremes included),
  // new idle behavior, and a run of random bytes. Most lengths are short so
  // many frames close; one phase uses the longest frame.
  task automatic test_random_frames();
    int phase;
    int sent;
    int n;
    logic [SYNC_W-1:0] r;
    phase = 0;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_symbols_drained();
      r = $urandom();
      case ($urandom_range(0, 3))
        0: write_reg(REG_AMPLITUDE, {r[31:AMP_W], {AMP_W{1'b0}}});
        1: write_reg(REG_AMPLITUDE, {r[31:AMP_W], AMP_MAX});
        default: write_reg(REG_AMPLITUDE, r);
      endcase
      if ($urandom_range(0, 2) == 0) write_reg(REG_SYNC_WORD, $urandom());
      r = $urandom();
      if (phase == 2)
        write_reg(REG_PAYLOAD_BYTES, {r[31:LEN_W], 8'd255});
      else if ($urandom_range(0, 3) == 0)
        write_reg(REG_PAYLOAD_BYTES, {r[31:LEN_W], 8'($urandom_range(7, 40))});
      else if ($urandom_range(0, 3) != 0)
        write_reg(REG_PAYLOAD_BYTES, {r[31:LEN_W], 8'($urandom_range(0, 6))});
      if ($urandom_range(0, 7) == 0) write_reg(REG_UNUSED, $urandom());
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      n = (phase == 2) ? 260 : $urandom_range(10, 40);
      repeat (n) send_byte($urandom_range(0, 255));
      sent += n;
      phase++;
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  initial begin
    rst        <= 1'b1;
    cfg_we     <= 1'b0;
    cfg_index  <= REG_AMPLITUDE;
    cfg_data   <= '0;
    byte_valid <= 1'b0;
    byte_value <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_values();
    test_mid_frame_changes();
    test_short_lengths();
    test_field_extremes();
    test_unused_index();
    test_backpressure();
    test_random_frames();

    // Let the last symbols drain, then watch a little longer for any
    // symbol that should not be there.
    wait_symbols_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
